@@ hw/rtl/cicd_pkg.sv @@
// ----------------------------------------------------------------------------
// cicd_pkg
// shared types and constants of the cloud-in-cell charge deposition block
// ----------------------------------------------------------------------------
package cicd_pkg;

    localparam int MESH_NX = 32;
    localparam int MESH_NY = 32;
    localparam int MESH_NZ = 32;
    localparam int XW      = $clog2(MESH_NX);
    localparam int YW      = $clog2(MESH_NY);
    localparam int ZW      = $clog2(MESH_NZ);
    localparam int DEPTH   = MESH_NX * MESH_NY * MESH_NZ;
    localparam int ADDR_W  = $clog2(DEPTH);

    localparam int DENS_W  = 48;
    localparam int NODE_W  = 5;
    localparam int IN_TDATA_W = 144;

    localparam logic [16:0] ONE_Q16 = 17'h10000;
    localparam logic signed [49:0] D_MAX = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [49:0] D_MIN = -D_MAX - 50'sd1;

    localparam logic [1:0] CMD_DEPOSIT    = 2'd0;
    localparam logic [1:0] CMD_READ       = 2'd1;
    localparam logic [1:0] CMD_READ_CLEAR = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_SKIPPED  = 2'd1;
    localparam logic [1:0] STAT_BAD_NODE = 2'd2;

    localparam logic [7:0] REG_INV_X   = 8'd0;
    localparam logic [7:0] REG_INV_Y   = 8'd1;
    localparam logic [7:0] REG_INV_Z   = 8'd2;
    localparam logic [7:0] REG_INV_VOL = 8'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCALE,
        ST_AXIS,
        ST_CORNER,
        ST_DRAIN,
        ST_RD_ADDR,
        ST_RD_WAIT,
        ST_DONE
    } state_t;

    function automatic logic [ADDR_W-1:0] node_addr(input logic [31:0] x,
                                                    input logic [31:0] y,
                                                    input logic [31:0] z);
        logic [63:0] a;
        a = ((64'(x) * 64'(MESH_NY)) + 64'(y)) * 64'(MESH_NZ) + 64'(z);
        return a[ADDR_W-1:0];
    endfunction

endpackage

@@ hw/rtl/cicd_ram.sv @@
// ----------------------------------------------------------------------------
// cicd_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module cicd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32768
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/cic_charge_deposition_3d.sv @@
// ----------------------------------------------------------------------------
// cic_charge_deposition_3d
// cloud-in-cell charge deposition onto a 3d density mesh
// ----------------------------------------------------------------------------
// s_ channel takes one command per transfer: a deposit (position, charge),
// a node read, or a node read-and-clear. every command gives exactly one
// transfer on the m_ channel with the node density (zero for deposits) and
// a status. cfg_ writes the four scale registers; the user must do so only
// while the block is idle, which the block itself does not enforce. a deposit
// runs two setup steps (position and charge multipliers, then axis nodes and
// weights; skipped with a status if a cell lies off the mesh), eight corner
// updates issued one per cycle into a five stage read-modify-write pipe on
// the mesh memory, a drain of the pipe, and the load of the result. a read
// runs an address step and, for a node on the mesh, a wait step. one item is
// worked on at a time; the next item is taken once the result sits in the
// output register, even while the receiver stalls it. after reset the mesh
// memory is swept to zero, one node per cycle, with s_tready low throughout.
// ----------------------------------------------------------------------------
module cic_charge_deposition_3d (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x, pos_y, pos_z, charge, node_x, node_y, node_z, zero pad
    input  logic [cicd_pkg::IN_TDATA_W-1:0] s_tdata,
    // command
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // density
    output logic [cicd_pkg::DENS_W-1:0] m_tdata,
    // status
    output logic [1:0]   m_tuser
);
    import cicd_pkg::*;

    state_t state_reg, state_next;

    logic [31:0] inv_x_reg, inv_y_reg, inv_z_reg, inv_vol_reg;
    logic [ADDR_W-1:0] clr_reg;

    logic [1:0]  cmd_reg;
    logic [31:0] px_reg, py_reg, pz_reg, chg_reg;
    logic [NODE_W-1:0] nx_reg, ny_reg, nz_reg;

    logic [63:0] gx_reg, gy_reg, gz_reg;
    logic signed [64:0] cq_reg;

    logic [XW-1:0] ux_reg;
    logic [YW-1:0] uy_reg;
    logic [ZW-1:0] uz_reg;
    logic [16:0] wux_reg, wuy_reg, wuz_reg;
    logic        neg_reg;
    logic [63:0] mag_reg;
    logic [2:0]  cnt_reg;

    logic              a_v_reg, b_v_reg, c_v_reg, d_v_reg, e_v_reg;
    logic [33:0]       a_wxy_reg;
    logic [16:0]       a_wz_reg;
    logic [ADDR_W-1:0] a_addr_reg, b_addr_reg, c_addr_reg, d_addr_reg, e_addr_reg;
    logic [32:0]       b_w_reg;
    logic [64:0]       c_ph_reg, c_pl_reg;
    logic signed [48:0] d_con_reg, e_con_reg;

    logic [DENS_W-1:0] res_dens_reg, res_dens_next;
    logic [1:0]        res_stat_reg, res_stat_next;
    logic [DENS_W-1:0] m_data_reg;
    logic [1:0]        m_user_reg;
    logic              m_valid_reg;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr, rd_addr;
    logic [DENS_W-1:0] ram_wdata, ram_rdata;

    logic s_xfer, out_load, issue, rd_bad, ok_x, ok_y, ok_z;
    logic [32:0] upx, upy, upz;
    logic [16:0] wx, wy, wz;
    logic [50:0] wprod;
    logic [64:0] prod;
    logic [63:0] pclip;
    logic signed [48:0] con;
    logic signed [49:0] sum, sum_sat;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign out_load  = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);
    assign issue     = (state_reg == ST_CORNER);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    // axis upper nodes and weights
    always_comb begin
        upx = (gx_reg[31:0] == 32'd0) ? {1'b0, gx_reg[63:32]} : {1'b0, gx_reg[63:32]} + 33'd1;
        upy = (gy_reg[31:0] == 32'd0) ? {1'b0, gy_reg[63:32]} : {1'b0, gy_reg[63:32]} + 33'd1;
        upz = (gz_reg[31:0] == 32'd0) ? {1'b0, gz_reg[63:32]} : {1'b0, gz_reg[63:32]} + 33'd1;
        ok_x = (upx >= 33'd1) && (upx < 33'(MESH_NX));
        ok_y = (upy >= 33'd1) && (upy < 33'(MESH_NY));
        ok_z = (upz >= 33'd1) && (upz < 33'(MESH_NZ));
    end

    assign rd_bad  = (32'(nx_reg) >= 32'(MESH_NX)) || (32'(ny_reg) >= 32'(MESH_NY))
                  || (32'(nz_reg) >= 32'(MESH_NZ));
    assign rd_addr = node_addr(32'(nx_reg), 32'(ny_reg), 32'(nz_reg));

    // corner weights
    always_comb begin
        wx = cnt_reg[0] ? ONE_Q16 - wux_reg : wux_reg;
        wy = cnt_reg[1] ? ONE_Q16 - wuy_reg : wuy_reg;
        wz = cnt_reg[2] ? ONE_Q16 - wuz_reg : wuz_reg;
        wprod = 51'(a_wxy_reg) * 51'(a_wz_reg);
    end

    // contribution with saturation
    always_comb begin
        prod = {1'b0, c_ph_reg[63:0]} + 65'(c_pl_reg[64:32]);
        if (prod > 65'(D_MAX)) begin
            pclip = 64'(D_MAX) + 64'(neg_reg);
        end else begin
            pclip = prod[63:0];
        end
        con = neg_reg ? -$signed({1'b0, pclip[47:0]}) : $signed({1'b0, pclip[47:0]});
        sum = 50'(signed'(ram_rdata)) + 50'(e_con_reg);
        if (sum > D_MAX) begin
            sum_sat = D_MAX;
        end else if (sum < D_MIN) begin
            sum_sat = D_MIN;
        end else begin
            sum_sat = sum;
        end
    end

    // memory port selection
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = e_addr_reg;
        ram_wdata = sum_sat[DENS_W-1:0];
        ram_raddr = (state_reg == ST_RD_ADDR) ? rd_addr : d_addr_reg;
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end else if (e_v_reg) begin
            ram_we = 1'b1;
        end else if (state_reg == ST_RD_WAIT && cmd_reg == CMD_READ_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = rd_addr;
            ram_wdata = '0;
        end
    end

    always_comb begin
        state_next    = state_reg;
        res_dens_next = res_dens_reg;
        res_stat_next = res_stat_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_xfer) begin
                    res_dens_next = '0;
                    res_stat_next = STAT_OK;
                    case (s_tuser)
                        CMD_DEPOSIT:    state_next = ST_SCALE;
                        CMD_READ:       state_next = ST_RD_ADDR;
                        CMD_READ_CLEAR: state_next = ST_RD_ADDR;
                        default:        state_next = ST_DONE;
                    endcase
                end
            end
            ST_SCALE: state_next = ST_AXIS;
            ST_AXIS: begin
                if (ok_x && ok_y && ok_z) begin
                    state_next = ST_CORNER;
                end else begin
                    res_stat_next = STAT_SKIPPED;
                    state_next    = ST_DONE;
                end
            end
            ST_CORNER: begin
                if (cnt_reg == 3'd7) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!(a_v_reg || b_v_reg || c_v_reg || d_v_reg || e_v_reg)) begin
                    state_next = ST_DONE;
                end
            end
            ST_RD_ADDR: begin
                if (rd_bad) begin
                    res_stat_next = STAT_BAD_NODE;
                    state_next    = ST_DONE;
                end else begin
                    state_next = ST_RD_WAIT;
                end
            end
            ST_RD_WAIT: begin
                res_dens_next = ram_rdata;
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            a_v_reg     <= 1'b0;
            b_v_reg     <= 1'b0;
            c_v_reg     <= 1'b0;
            d_v_reg     <= 1'b0;
            e_v_reg     <= 1'b0;
            cnt_reg     <= '0;
            inv_x_reg   <= 32'h0001_0000;
            inv_y_reg   <= 32'h0001_0000;
            inv_z_reg   <= 32'h0001_0000;
            inv_vol_reg <= 32'h0001_0000;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + ADDR_W'(1);
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_INV_X:   inv_x_reg   <= cfg_data;
                    REG_INV_Y:   inv_y_reg   <= cfg_data;
                    REG_INV_Z:   inv_z_reg   <= cfg_data;
                    REG_INV_VOL: inv_vol_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            cnt_reg <= issue ? cnt_reg + 3'd1 : 3'd0;
            a_v_reg <= issue;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg;
            e_v_reg <= d_v_reg;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            cmd_reg <= s_tuser;
            px_reg  <= s_tdata[31:0];
            py_reg  <= s_tdata[63:32];
            pz_reg  <= s_tdata[95:64];
            chg_reg <= s_tdata[127:96];
            nx_reg  <= s_tdata[132:128];
            ny_reg  <= s_tdata[137:133];
            nz_reg  <= s_tdata[142:138];
        end
        res_dens_reg <= res_dens_next;
        res_stat_reg <= res_stat_next;
        if (out_load) begin
            m_data_reg <= res_dens_reg;
            m_user_reg <= res_stat_reg;
        end
        if (state_reg == ST_SCALE) begin
            gx_reg <= 64'(px_reg) * 64'(inv_x_reg);
            gy_reg <= 64'(py_reg) * 64'(inv_y_reg);
            gz_reg <= 64'(pz_reg) * 64'(inv_z_reg);
            cq_reg <= 65'($signed(chg_reg)) * $signed({33'd0, inv_vol_reg});
        end
        if (state_reg == ST_AXIS) begin
            ux_reg  <= upx[XW-1:0];
            uy_reg  <= upy[YW-1:0];
            uz_reg  <= upz[ZW-1:0];
            wux_reg <= (gx_reg[31:0] == 32'd0) ? ONE_Q16 : {1'b0, gx_reg[31:16]};
            wuy_reg <= (gy_reg[31:0] == 32'd0) ? ONE_Q16 : {1'b0, gy_reg[31:16]};
            wuz_reg <= (gz_reg[31:0] == 32'd0) ? ONE_Q16 : {1'b0, gz_reg[31:16]};
            neg_reg <= cq_reg[64];
            mag_reg <= cq_reg[64] ? 64'(-cq_reg) : cq_reg[63:0];
        end
        a_wxy_reg  <= 34'(wx) * 34'(wy);
        a_wz_reg   <= wz;
        a_addr_reg <= node_addr(32'(ux_reg) - 32'(cnt_reg[0]),
                                32'(uy_reg) - 32'(cnt_reg[1]),
                                32'(uz_reg) - 32'(cnt_reg[2]));
        b_w_reg    <= wprod[48:16];
        b_addr_reg <= a_addr_reg;
        c_ph_reg   <= 65'(mag_reg[63:32]) * 65'(b_w_reg);
        c_pl_reg   <= 65'(mag_reg[31:0]) * 65'(b_w_reg);
        c_addr_reg <= b_addr_reg;
        d_con_reg  <= con;
        d_addr_reg <= c_addr_reg;
        e_con_reg  <= d_con_reg;
        e_addr_reg <= d_addr_reg;
    end

    cicd_ram #(
        .WIDTH (DENS_W),
        .DEPTH (DEPTH)
    ) u_mesh (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // a corner update only lands while a deposit is in flight
    a_corner_write: assert property (@(posedge aclk) disable iff (!aresetn)
        e_v_reg |-> (state_reg == ST_CORNER || state_reg == ST_DRAIN))
        else $error("corner write outside deposit");

    // no new transfer while the mesh sweep runs
    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !s_tready)
        else $error("input taken during clear");

    // a result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_tready))
        else $error("result overwritten");

    // the pipe is empty whenever a new item can be taken
    a_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !(a_v_reg || b_v_reg || c_v_reg || d_v_reg || e_v_reg))
        else $error("item accepted with pipe busy");

endmodule
